[rtl/core/pip_pkg.sv]
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W      = 16;
	localparam int TOTAL_W      = 7;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_TEST   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_DUP   = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]                func;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} in_t;

	typedef struct packed {
		logic               inside_res;
		logic [1:0]         status;
		logic [TOTAL_W-1:0] vertex_total;
	} out_t;

endpackage

[rtl/core/pip_ram.sv]
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/point_in_polygon_test_unit.sv]
// Point-in-polygon tester, even-odd crossing rule over a vertex table.
// Input channel (in_valid/in_ready/in_data) carries one request per
// transaction: clear the table, append a vertex, or test a point.
// Output channel (out_valid/out_ready/out_data) returns exactly one result
// per request: inside flag, status and the vertex count after the request.
// Clear, append, the unused code and a test of an empty table register their
// result in res_q on acceptance and then pass it to the output register.
// A test reads the vertex RAM once per vertex plus one extra read for the
// closing edge, then drains a two-stage multiply and compare pipeline.
// The single RAM read port, one edge per cycle, sets the test time.
// A new request is taken once the previous one has handed its result to
// the output register, so one result may wait in out_data while the next
// request is already being worked on. If the receiver stalls, the finished
// result is held until the output register frees up.
// Reset empties the table and drops any pending result; RAM contents are
// left as they are and are only read below the vertex count.
module point_in_polygon_test_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pip_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output pip_pkg::out_t out_data
);
	import pip_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_RES   = 2'd3;

	logic [1:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] iss_q;
	logic signed [COORD_W-1:0] last_x_q, last_y_q;
	logic signed [COORD_W-1:0] tx_q, ty_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic inside_q;
	out_t res_q;
	out_t out_q;
	logic out_valid_q;

	logic v_s1, first_s1;
	logic v_s2, dpos_s2, cross_s2;
	logic signed [PROD_W-1:0] lhs_s2, rhs_s2;

	logic accept;
	logic is_dup, is_full;
	logic ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [2*COORD_W-1:0] ram_wdata, ram_rdata;
	logic signed [COORD_W-1:0] cur_x, cur_y;
	logic signed [DIFF_W-1:0] diff_a, diff_b, diff_c, diff_d;
	logic [CNT_W-1:0] cnt_inc;
	logic left;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_dup  = (cnt_q != '0) && (last_x_q == in_data.coord_x) &&
		(last_y_q == in_data.coord_y);
	assign is_full = (cnt_q >= CNT_W'(MAX_VERTICES));
	assign cnt_inc = cnt_q + CNT_W'(1);

	assign ram_we    = accept && (in_data.func == FUNC_APPEND) && !is_dup && !is_full;
	assign ram_waddr = cnt_q[ADDR_W-1:0];
	assign ram_wdata = {in_data.coord_x, in_data.coord_y};
	// first read fetches the last vertex so the closing edge comes first
	assign ram_re    = (state_q == ST_SCAN);
	assign ram_raddr = (iss_q == '0) ? ADDR_W'(cnt_q - CNT_W'(1)) :
		ADDR_W'(iss_q - CNT_W'(1));

	pip_ram #(
		.WIDTH(2 * COORD_W),
		.DEPTH(MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cur_x = $signed(ram_rdata[2*COORD_W-1:COORD_W]);
	assign cur_y = $signed(ram_rdata[COORD_W-1:0]);

	// edge (i = cur, j = prev); compare (tx-xi)*d against (xj-xi)*(ty-yi)
	assign diff_a = $signed({tx_q[COORD_W-1], tx_q}) - $signed({cur_x[COORD_W-1], cur_x});
	assign diff_b = $signed({prev_x_q[COORD_W-1], prev_x_q}) -
		$signed({cur_x[COORD_W-1], cur_x});
	assign diff_c = $signed({ty_q[COORD_W-1], ty_q}) - $signed({cur_y[COORD_W-1], cur_y});
	assign diff_d = $signed({prev_y_q[COORD_W-1], prev_y_q}) -
		$signed({cur_y[COORD_W-1], cur_y});

	assign left = dpos_s2 ? (lhs_s2 < rhs_s2) : (lhs_s2 > rhs_s2);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		if (v_s1 && !first_s1) begin
			lhs_s2   <= diff_a * diff_d;
			rhs_s2   <= diff_b * diff_c;
			dpos_s2  <= (prev_y_q > cur_y);
			cross_s2 <= (cur_y > ty_q) != (prev_y_q > ty_q);
		end
		if (accept) begin
			tx_q <= in_data.coord_x;
			ty_q <= in_data.coord_y;
		end
		if (ram_we) begin
			last_x_q <= in_data.coord_x;
			last_y_q <= in_data.coord_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			iss_q       <= '0;
			inside_q    <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			first_s1    <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			v_s1     <= ram_re;
			first_s1 <= (iss_q == '0);
			v_s2     <= v_s1 && !first_s1;
			if (v_s2 && cross_s2 && left) begin
				inside_q <= !inside_q;
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q.inside_res   <= 1'b0;
						res_q.status       <= STAT_OK;
						res_q.vertex_total <= TOTAL_W'(cnt_q);
						inside_q           <= 1'b0;
						iss_q              <= '0;
						state_q            <= ST_RES;
						case (in_data.func)
							FUNC_CLEAR: begin
								cnt_q              <= '0;
								res_q.vertex_total <= '0;
							end
							FUNC_APPEND: begin
								if (is_dup) begin
									res_q.status <= STAT_DUP;
								end else if (is_full) begin
									res_q.status <= STAT_FULL;
								end else begin
									cnt_q              <= cnt_inc;
									res_q.vertex_total <= TOTAL_W'(cnt_inc);
								end
							end
							FUNC_TEST: begin
								if (cnt_q == '0) begin
									res_q.status <= STAT_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					iss_q <= iss_q + CNT_W'(1);
					if (iss_q == cnt_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						res_q.inside_res <= inside_q;
						state_q          <= ST_RES;
					end
				end
				ST_RES: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/pip_checker.sv]
module pip_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input pip_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input pip_pkg::out_t out_data
);
	import pip_pkg::*;

	// a waiting request must hold
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed while waiting");

	// a stalled result must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_EMPTY) |-> (out_data.vertex_total == '0))
		else $error("empty status with nonzero vertex total");

	a_inside_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.inside_res |->
			(out_data.status == STAT_OK) && (out_data.vertex_total >= TOTAL_W'(3)))
		else $error("inside reported for a degenerate polygon or failed request");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_FULL) |->
			(out_data.vertex_total == TOTAL_W'(MAX_VERTICES)))
		else $error("full status below table capacity");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
